// ===== hdl/crcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame
// checker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  OWN_ADDR_RST = 8'h02;
    localparam logic [7:0]  MIN_LEN_RST  = 8'd21;

    // Verdict codes, in the order the checks are made.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_CRC_FAIL   = 3'd2,
        ST_WRONG_DEST = 3'd3,
        ST_LEN_SHORT  = 3'd4
    } t_status;

    // Register index on the configuration port.
    typedef enum logic {
        REG_OWN_ADDRESS        = 1'b0,
        REG_MIN_PAYLOAD_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] min_payload_length;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [7:0]  frame_flags;
        logic [7:0]  payload_length;
        logic [15:0] received_check;
        logic [15:0] computed_check;
        logic [7:0]  destination;
        logic [7:0]  source;
    } t_result;

    // CRC-16/CCITT-FALSE over one byte, MSB first, eight bit steps unrolled.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crcfc_cfg_regs
// APB-style register file holding the node address and the minimum payload
// length.
// ----------------------------------------------------------------------------
module crcfc_cfg_regs
    import crcfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_OWN_ADDRESS:        n_cfg.own_address        = pwdata[7:0];
                REG_MIN_PAYLOAD_LENGTH: n_cfg.min_payload_length = pwdata[7:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address        <= OWN_ADDR_RST;
            r_cfg.min_payload_length <= MIN_LEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OWN_ADDRESS:        prdata = {24'd0, r_cfg.own_address};
            REG_MIN_PAYLOAD_LENGTH: prdata = {24'd0, r_cfg.min_payload_length};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/crcfc_frame.sv =====
// ----------------------------------------------------------------------------
// crcfc_frame
// Per-frame state: byte count, running CRC and captured header fields, plus
// the verdict logic for the final byte.
// ----------------------------------------------------------------------------
module crcfc_frame
    import crcfc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int LEN_OFS     = 4 + PAYLOAD_BYTES;
    localparam int TOTAL_BYTES = 9 + PAYLOAD_BYTES;
    localparam int CNT_W       = $clog2(TOTAL_BYTES + 1);

    localparam logic [CNT_W-1:0] POS_TYPE  = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SEQ_L = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_SEQ_H = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_FLAGS = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_LEN   = CNT_W'(LEN_OFS);
    localparam logic [CNT_W-1:0] POS_CRC_L = CNT_W'(LEN_OFS + 1);
    localparam logic [CNT_W-1:0] POS_CRC_H = CNT_W'(LEN_OFS + 2);
    localparam logic [CNT_W-1:0] POS_DEST  = CNT_W'(LEN_OFS + 3);
    localparam logic [CNT_W-1:0] POS_SRC   = CNT_W'(LEN_OFS + 4);
    localparam logic [CNT_W-1:0] POS_FULL  = CNT_W'(TOTAL_BYTES);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_seq, n_seq;
    logic [7:0]       r_flags, n_flags;
    logic [7:0]       r_len, n_len;
    logic [15:0]      r_chk, n_chk;
    logic [7:0]       r_dest, n_dest;
    logic [7:0]       r_src, n_src;
    t_status          w_status;

    // Field capture and CRC update for the byte at the current position.
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_type  = r_type;
        n_seq   = r_seq;
        n_flags = r_flags;
        n_len   = r_len;
        n_chk   = r_chk;
        n_dest  = r_dest;
        n_src   = r_src;
        if (r_count < POS_FULL) begin
            if (r_count <= POS_LEN) begin
                n_crc = crc_byte(r_crc, i_rx_byte);
            end
            if (r_count == POS_TYPE)       n_type      = i_rx_byte;
            if (r_count == POS_SEQ_L)      n_seq[7:0]  = i_rx_byte;
            if (r_count == POS_SEQ_H)      n_seq[15:8] = i_rx_byte;
            if (r_count == POS_FLAGS)      n_flags     = i_rx_byte;
            if (r_count == POS_LEN)        n_len       = i_rx_byte;
            if (r_count == POS_CRC_L)      n_chk[7:0]  = i_rx_byte;
            if (r_count == POS_CRC_H)      n_chk[15:8] = i_rx_byte;
            if (r_count == POS_DEST)       n_dest      = i_rx_byte;
            if (r_count == POS_SRC)        n_src       = i_rx_byte;
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        priority if (n_count < POS_FULL)            w_status = ST_SHORT;
        else if (n_crc != n_chk)                     w_status = ST_CRC_FAIL;
        else if (n_dest != i_cfg.own_address)        w_status = ST_WRONG_DEST;
        else if (n_len < i_cfg.min_payload_length)   w_status = ST_LEN_SHORT;
        else                                         w_status = ST_OK;
    end

    assign o_res_valid          = i_step & i_last_byte;
    assign o_res.status         = w_status;
    assign o_res.frame_type     = n_type;
    assign o_res.sequence_res   = n_seq;
    assign o_res.frame_flags    = n_flags;
    assign o_res.payload_length = n_len;
    assign o_res.received_check = n_chk;
    assign o_res.computed_check = n_crc;
    assign o_res.destination    = n_dest;
    assign o_res.source         = n_src;

    // A verdict rearms the state for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_type  <= '0;
            r_seq   <= '0;
            r_flags <= '0;
            r_len   <= '0;
            r_chk   <= '0;
            r_dest  <= '0;
            r_src   <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_seq   <= n_seq;
            r_flags <= n_flags;
            r_len   <= n_len;
            r_chk   <= n_chk;
            r_dest  <= n_dest;
            r_src   <= n_src;
        end
    end

endmodule

// ===== hdl/crc16_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_checker_core
// Checks received frames byte by byte with a CRC-16/CCITT-FALSE and returns
// one verdict item with the captured header fields per frame.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_rx_byte, i_last_byte
//  out      | output    | o_out_valid / i_out_stall | o_status .. o_source
//  config   | APB write | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One byte item is accepted per cycle while o_in_stall is low. Each item is
// held in the input register, and there the CRC byte update and capture logic
// work on it; a final byte's verdict is then loaded into the output register,
// which offers it as a verdict item once the output register has room for
// it.
// Reset (synchronous, active low) empties both registers, rearms the frame
// state and loads the register defaults (address 0x02, minimum length 21).
// While a verdict waits on a stalled output, non-final bytes keep flowing;
// only a final byte behind it holds in the input register and raises stall.
//
module crc16_frame_checker_core
    import crcfc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_sequence_res,
    output logic [7:0]  o_frame_flags,
    output logic [7:0]  o_payload_length,
    output logic [15:0] o_received_check,
    output logic [15:0] o_computed_check,
    output logic [7:0]  o_destination,
    output logic [7:0]  o_source,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       w_cfg;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register.
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_advance;
    logic       w_step;
    logic       w_accept;
    logic       w_res_valid;
    t_result    w_res;

    crcfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The output register can take a new verdict when it is empty or its
    // current item leaves this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // Only a final byte needs room in the output register.
    assign w_advance  = !r_in_last || w_out_free;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    crcfc_frame #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_rx_byte   (r_in_byte),
        .i_last_byte (r_in_last),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_frame_type     = r_out.frame_type;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_frame_flags    = r_out.frame_flags;
    assign o_payload_length = r_out.payload_length;
    assign o_received_check = r_out.received_check;
    assign o_computed_check = r_out.computed_check;
    assign o_destination    = r_out.destination;
    assign o_source         = r_out.source;

endmodule

// ===== hdl/crcfc_checker.sv =====
// ----------------------------------------------------------------------------
// crcfc_checker
// Port-level assertions for the frame checker, attached by bind.
// ----------------------------------------------------------------------------
module crcfc_checker
    import crcfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_received_check,
    input logic [15:0] o_computed_check,
    input logic        pready
);

    // A verdict held back by stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // Reset leaves no verdict pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict present after reset");

    // Only the five defined verdict codes are produced.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_LEN_SHORT))
        else $error("undefined verdict code");

    // A verdict that passed the CRC check cannot carry mismatching received and
    // computed checks.
    a_crc_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK || o_status == ST_WRONG_DEST
                        || o_status == ST_LEN_SHORT)
        |-> (o_received_check == o_computed_check))
        else $error("verdict passed CRC but checks differ");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind crc16_frame_checker_core crcfc_checker u_crcfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_received_check (o_received_check),
    .o_computed_check (o_computed_check),
    .pready           (pready)
);

// ===== tb/frame_verdict_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_verdict_checker
// Watches the byte, verdict and register channels of the frame checker,
// tracks frame state on its own, and compares every verdict item with the
// one it predicted.
// ----------------------------------------------------------------------------
module frame_verdict_checker
    import crcfc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_frame_type,
    input  logic [15:0] i_sequence_res,
    input  logic [7:0]  i_frame_flags,
    input  logic [7:0]  i_payload_length,
    input  logic [15:0] i_received_check,
    input  logic [15:0] i_computed_check,
    input  logic [7:0]  i_destination,
    input  logic [7:0]  i_source,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          o_fail_count,
    output int          o_pending
);

    localparam int          LEN_POS     = 4 + PAYLOAD_BYTES;
    localparam int          FRAME_BYTES = 9 + PAYLOAD_BYTES;
    localparam logic [15:0] GEN_POLY    = 16'h1021;
    localparam int          REPORT_MAX  = 10;

    logic [7:0]  own_addr;
    logic [7:0]  min_len;

    logic [5:0]  pos_cnt;
    logic [15:0] crc_run;
    logic [7:0]  type_q;
    logic [15:0] seq_q;
    logic [7:0]  flags_q;
    logic [7:0]  len_q;
    logic [15:0] rxcrc_q;
    logic [7:0]  dst_q;
    logic [7:0]  src_q;

    t_result     expected_verdicts[$];
    int          fails;

    // Bit-serial form of the CRC-16 update; the stimulus uses it too.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ GEN_POLY;
            end
        end
        return r;
    endfunction

    task automatic clear_frame();
        pos_cnt = '0;
        crc_run = CRC_INIT;
        type_q  = '0;
        seq_q   = '0;
        flags_q = '0;
        len_q   = '0;
        rxcrc_q = '0;
        dst_q   = '0;
        src_q   = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_result v;
        if (pos_cnt < FRAME_BYTES) begin
            if (pos_cnt <= LEN_POS) begin
                crc_run = crc16_next(crc_run, b);
            end
            if (pos_cnt == 0) begin
                type_q = b;
            end else if (pos_cnt == 1) begin
                seq_q[7:0] = b;
            end else if (pos_cnt == 2) begin
                seq_q[15:8] = b;
            end else if (pos_cnt == 3) begin
                flags_q = b;
            end else if (pos_cnt == LEN_POS) begin
                len_q = b;
            end else if (pos_cnt == LEN_POS + 1) begin
                rxcrc_q[7:0] = b;
            end else if (pos_cnt == LEN_POS + 2) begin
                rxcrc_q[15:8] = b;
            end else if (pos_cnt == LEN_POS + 3) begin
                dst_q = b;
            end else if (pos_cnt == LEN_POS + 4) begin
                src_q = b;
            end
            pos_cnt = pos_cnt + 6'd1;
        end
        if (last) begin
            if (pos_cnt < FRAME_BYTES) begin
                v.status = ST_SHORT;
            end else if (crc_run != rxcrc_q) begin
                v.status = ST_CRC_FAIL;
            end else if (dst_q != own_addr) begin
                v.status = ST_WRONG_DEST;
            end else if (len_q < min_len) begin
                v.status = ST_LEN_SHORT;
            end else begin
                v.status = ST_OK;
            end
            v.frame_type     = type_q;
            v.sequence_res   = seq_q;
            v.frame_flags    = flags_q;
            v.payload_length = len_q;
            v.received_check = rxcrc_q;
            v.computed_check = crc_run;
            v.destination    = dst_q;
            v.source         = src_q;
            expected_verdicts.push_back(v);
            clear_frame();
        end
    endtask

    task automatic compare_verdict();
        t_result e;
        if (expected_verdicts.size() == 0) begin
            if (fails < REPORT_MAX) begin
                $display("verdict item with none expected: status %0d crc %h",
                         i_status, i_computed_check);
            end
            fails++;
        end else begin
            e = expected_verdicts.pop_front();
            if (i_status !== e.status || i_frame_type !== e.frame_type
                    || i_sequence_res !== e.sequence_res
                    || i_frame_flags !== e.frame_flags
                    || i_payload_length !== e.payload_length
                    || i_received_check !== e.received_check
                    || i_computed_check !== e.computed_check
                    || i_destination !== e.destination
                    || i_source !== e.source) begin
                if (fails < REPORT_MAX) begin
                    $display("verdict mismatch, expected: st %0d ty %h seq %h fl %h len %h rx %h crc %h dst %h src %h",
                             e.status, e.frame_type, e.sequence_res, e.frame_flags,
                             e.payload_length, e.received_check, e.computed_check,
                             e.destination, e.source);
                    $display("                  actual:   st %0d ty %h seq %h fl %h len %h rx %h crc %h dst %h src %h",
                             i_status, i_frame_type, i_sequence_res, i_frame_flags,
                             i_payload_length, i_received_check, i_computed_check,
                             i_destination, i_source);
                end
                fails++;
            end
        end
    endtask

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr = OWN_ADDR_RST;
            min_len  = MIN_LEN_RST;
            clear_frame();
            expected_verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_verdict();
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (t_reg_idx'(paddr[2]))
                    REG_OWN_ADDRESS:        own_addr = pwdata[7:0];
                    REG_MIN_PAYLOAD_LENGTH: min_len  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_byte(i_rx_byte, i_last_byte);
            end
        end
        o_pending    <= expected_verdicts.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_crc16_frame_checker_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_checker_core
// Drives received frames into the CRC-16 frame checker, byte by byte, under
// random sender gaps and receiver stalls, reprograms the address and length
// registers between phases, and reports the verdict of the checker module.
// ----------------------------------------------------------------------------
module tb_crc16_frame_checker_core;
    import crcfc_pkg::*;

    localparam int PAYLOAD_BYTES  = 32;
    localparam int FRAME_BYTES    = 9 + PAYLOAD_BYTES;
    // The core offers a verdict from the output register, behind the input
    // register; the wait lets any byte in flight finish before a register write.
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 600;
    localparam int MIN_VERDICTS   = 40;
    localparam int PHASE_FRAMES   = 5;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_last_byte;

    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_frame_type;
    logic [15:0] o_sequence_res;
    logic [7:0]  o_frame_flags;
    logic [7:0]  o_payload_length;
    logic [15:0] o_received_check;
    logic [15:0] o_computed_check;
    logic [7:0]  o_destination;
    logic [7:0]  o_source;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          chk_fails;
    int          chk_pending;

    // Frame under construction, plus the register values the stimulus aims at.
    logic [7:0]  frame_q[$];
    logic [7:0]  cur_own;
    logic [7:0]  cur_min;
    int          random_bytes;
    int          verdicts_sent;
    int          idle_cycles;

    // Each side keeps a count of items still to go without any idling, so
    // that stretches of back-to-back traffic show up between the random gaps.
    int          in_calm;
    int          out_calm;
    bit          holdoff_req;

    always #6 i_clk = ~i_clk;

    crc16_frame_checker_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_frame_type     (o_frame_type),
        .o_sequence_res   (o_sequence_res),
        .o_frame_flags    (o_frame_flags),
        .o_payload_length (o_payload_length),
        .o_received_check (o_received_check),
        .o_computed_check (o_computed_check),
        .o_destination    (o_destination),
        .o_source         (o_source),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    frame_verdict_checker #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_frame_type     (o_frame_type),
        .i_sequence_res   (o_sequence_res),
        .i_frame_flags    (o_frame_flags),
        .i_payload_length (o_payload_length),
        .i_received_check (o_received_check),
        .i_computed_check (o_computed_check),
        .i_destination    (o_destination),
        .i_source         (o_source),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_fail_count     (chk_fails),
        .o_pending        (chk_pending)
    );

    // Idle cycles before the next item on one side: zero inside a calm
    // stretch, otherwise 0 to 6. Now and then a new calm stretch begins.
    function automatic int draw_wait(input bit rx_side);
        int calm;
        calm = rx_side ? out_calm : in_calm;
        if (calm > 0) begin
            calm--;
        end else if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
        end
        if (rx_side) begin
            out_calm = calm;
        end else begin
            in_calm = calm;
        end
        return (calm > 0) ? 0 : $urandom_range(0, 6);
    endfunction

    // Offers one byte item and returns at the falling edge after it was taken.
    // Valid stays high into the next item when no gap is drawn, so it is never
    // dropped and raised within one time step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait(1'b0);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_rx_byte   = b;
        i_last_byte = last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Sends the first count bytes of the frame buffer, the last one flagged.
    task automatic send_frame(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(frame_q[k], k == count - 1);
        end
        verdicts_sent++;
    endtask

    // Builds a full frame in the buffer. A negative fill gives a random
    // payload. crc_flip corrupts the carried CRC; extra appends trailing
    // bytes that the core must ignore.
    task automatic assemble_frame(input logic [7:0]  ftype,
                                  input logic [15:0] seq,
                                  input logic [7:0]  flags,
                                  input int          fill,
                                  input logic [7:0]  plen,
                                  input logic [7:0]  dst,
                                  input logic [7:0]  src,
                                  input logic [15:0] crc_flip,
                                  input int          extra);
        logic [15:0] crc;
        frame_q.delete();
        frame_q.push_back(ftype);
        frame_q.push_back(seq[7:0]);
        frame_q.push_back(seq[15:8]);
        frame_q.push_back(flags);
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        frame_q.push_back(plen);
        // Everything up to here, the length byte included, is CRC-covered.
        crc = CRC_INIT;
        for (int k = 0; k < frame_q.size(); k++) begin
            crc = u_chk.crc16_next(crc, frame_q[k]);
        end
        crc = crc ^ crc_flip;
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(dst);
        frame_q.push_back(src);
        repeat (extra) frame_q.push_back(8'($urandom));
    endtask

    // One random frame. Most are well formed with random content and a
    // destination and length near the current registers; the rest carry a
    // bad CRC, trailing bytes, an early end, or are plain noise.
    task automatic random_frame();
        int          kind;
        int          count;
        logic [7:0]  plen;
        logic [7:0]  dst;
        case ($urandom_range(0, 3))
            0:       plen = cur_min;
            1:       plen = cur_min - 8'd1;
            default: plen = 8'($urandom);
        endcase
        dst  = ($urandom_range(0, 2) != 0) ? cur_own : 8'($urandom);
        kind = $urandom_range(0, 9);
        assemble_frame(8'($urandom), 16'($urandom), 8'($urandom), -1, plen, dst,
                       8'($urandom),
                       (kind == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000,
                       (kind == 1) ? $urandom_range(1, 40) : 0);
        count = frame_q.size();
        if (kind == 2) begin
            count = $urandom_range(1, FRAME_BYTES - 1);
        end else if (kind == 3) begin
            frame_q.delete();
            repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
            count = frame_q.size();
        end
        random_bytes += count;
        send_frame(count);
    endtask

    // Waits until every expected verdict has come out and the core has had
    // time to finish any byte still inside, leaving the byte channel idle.
    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Two-phase register write: setup, then access. pready is always high,
    // so the write lands at the edge after penable rises. Upper data bits
    // are random since the registers keep only the low byte.
    task automatic reg_write(input t_reg_idx idx, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] own, input logic [7:0] min_pl);
        settle_idle();
        reg_write(REG_OWN_ADDRESS, own);
        reg_write(REG_MIN_PAYLOAD_LENGTH, min_pl);
        cur_own = own;
        cur_min = min_pl;
    endtask

    // Watchdog: a run that accepts nothing on any channel for too long is
    // stuck. The long receiver hold-off stays far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: before each verdict item it stalls for a drawn number of
    // cycles. When the stimulus asks for it, one stall is a long hold-off
    // counted here, so the core fills up and pushes back on its input.
    initial begin
        int n;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = draw_wait(1'b1);
            if (holdoff_req) begin
                n           = HOLDOFF_CYCLES;
                holdoff_req = 1'b0;
            end
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int phase;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_last_byte   = 1'b0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        holdoff_req   = 1'b0;
        cur_own       = OWN_ADDR_RST;
        cur_min       = MIN_LEN_RST;
        random_bytes  = 0;
        verdicts_sent = 0;
        idle_cycles   = 0;
        in_calm       = 0;
        out_calm      = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames under the reset register values. A clean frame of
        // all zeros with the length at its minimum, and one of all ones.
        assemble_frame(8'h00, 16'h0000, 8'h00, 0, cur_min, cur_own, 8'h00, 16'h0, 0);
        send_frame(frame_q.size());
        assemble_frame(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, cur_own, 8'hFF, 16'h0, 0);
        send_frame(frame_q.size());
        // Each failing check alone: bad CRC, foreign destination, length one
        // below the minimum.
        assemble_frame(8'h5A, 16'h1234, 8'hA5, -1, 8'd40, cur_own, 8'h11, 16'h0001, 0);
        send_frame(frame_q.size());
        assemble_frame(8'h01, 16'h8001, 8'h80, -1, 8'd40, cur_own + 8'd1, 8'h22, 16'h0, 0);
        send_frame(frame_q.size());
        assemble_frame(8'h80, 16'h00FF, 8'h01, -1, cur_min - 8'd1, cur_own, 8'h33, 16'h0, 0);
        send_frame(frame_q.size());
        // A bad CRC outranks a wrong destination and a short length.
        assemble_frame(8'h7E, 16'hFF00, 8'h7F, -1, 8'd0, 8'hFF, 8'h44, 16'h8000, 0);
        send_frame(frame_q.size());
        // Short frames: one byte, three bytes (type and sequence number), and
        // one byte short of complete (no source yet).
        assemble_frame(8'hC3, 16'hBEEF, 8'h3C, -1, 8'd30, cur_own, 8'h55, 16'h0, 0);
        send_frame(1);
        send_frame(3);
        send_frame(FRAME_BYTES - 1);
        // Trailing bytes past the full frame, enough to run the byte count
        // past 63 if it failed to stop at the frame length.
        assemble_frame(8'h3C, 16'h4321, 8'h99, -1, 8'd25, cur_own, 8'h66, 16'h0, 40);
        send_frame(frame_q.size());

        // Back-pressure: the receiver holds off while single-byte frames
        // keep coming, so verdicts pile up and the core stalls its input.
        settle_idle();
        holdoff_req = 1'b1;
        repeat (16) begin
            frame_q.delete();
            frame_q.push_back(8'($urandom));
            send_frame(1);
        end

        // Random phases, the first ones at the register extremes and back
        // at the reset values, later ones at random settings.
        phase = 0;
        while (phase < 3 || random_bytes < RANDOM_BYTES || verdicts_sent < MIN_VERDICTS) begin
            case (phase)
                0:       set_config(8'h00, 8'h00);
                1:       set_config(8'hFF, 8'hFF);
                2:       set_config(OWN_ADDR_RST, MIN_LEN_RST);
                default: set_config(8'($urandom), 8'($urandom));
            endcase
            repeat (PHASE_FRAMES) random_frame();
            phase++;
        end

        i_in_valid = 1'b0;
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (chk_fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
